// ===== rtl/hcrd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcrd_pkg: shared types and constants of the hex character reference decoder
// Holds the transaction structs, the controller/datapath interface and the
// character codes used to recognize a numeric reference.
// ----------------------------------------------------------------------------
package hcrd_pkg;

   localparam int MAX_DIGITS_DEFAULT = 6;

   localparam logic [7:0] CHAR_AMP  = 8'h26;
   localparam logic [7:0] CHAR_HASH = 8'h23;
   localparam logic [7:0] CHAR_X    = 8'h78;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_DIG0 = 8'h30;
   localparam logic [7:0] CHAR_DIG9 = 8'h39;
   localparam logic [7:0] CHAR_LA   = 8'h61;
   localparam logic [7:0] CHAR_LF   = 8'h66;
   localparam logic [7:0] CHAR_UA   = 8'h41;
   localparam logic [7:0] CHAR_UF   = 8'h46;

   typedef enum logic [1:0] {
      MODE_PLAIN = 2'd0,
      MODE_AMP   = 2'd1,
      MODE_HASH  = 2'd2,
      MODE_HEX   = 2'd3
   } mode_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_run_last;
      logic       out_stream_end;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic emit_flush;
      logic emit_tail;
   } cmd_type;

   typedef struct packed {
      logic first_emit;
      logic go_flush;
      logic go_tail;
      logic flush_at_last;
      logic tail_pend;
   } sts_type;

   // Returns {is_hex, digit value}.
   function automatic logic [4:0] hex_digit(input logic [7:0] ch);
      logic [4:0] r;
      r = 5'd0;
      if (ch >= CHAR_DIG0 && ch <= CHAR_DIG9) begin
         r = {1'b1, 4'(ch - CHAR_DIG0)};
      end else if (ch >= CHAR_LA && ch <= CHAR_LF) begin
         r = {1'b1, 4'(ch - CHAR_LA + 8'd10)};
      end else if (ch >= CHAR_UA && ch <= CHAR_UF) begin
         r = {1'b1, 4'(ch - CHAR_UA + 8'd10)};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/hcrd_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcrd_ctrl: sequencing controller
// Decides when a transaction is taken and steps the datapath through the
// released bytes of a reference, one result per cycle unless stalled.
// ----------------------------------------------------------------------------
module hcrd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   input  wire hcrd_pkg::sts_type sts,
   output hcrd_pkg::cmd_type     cmd
);
   import hcrd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_TAIL
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      idle;

   always_comb begin
      out_free       = !rsp_valid_ff || !rsp_stall;
      idle           = (state_ff == ST_IDLE);
      req_stall      = !(idle && out_free);
      cmd.accept     = req_valid && idle && out_free;
      cmd.emit_flush = (state_ff == ST_FLUSH) && out_free;
      cmd.emit_tail  = (state_ff == ST_TAIL) && out_free;

      state_in     = state_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free) begin
               rsp_valid_in = sts.first_emit;
               if (sts.go_flush) begin
                  state_in = ST_FLUSH;
               end else if (sts.go_tail) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (sts.flush_at_last) begin
                  state_in = sts.tail_pend ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/hcrd_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcrd_datapath: match state, held characters and result register
// Tracks the reference being matched, accumulates its value and produces
// each result byte on command from the controller.
// ----------------------------------------------------------------------------
module hcrd_datapath #(
   parameter int MAX_DIGITS = hcrd_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire hcrd_pkg::req_type req_data,
   input  wire hcrd_pkg::cmd_type cmd,
   output hcrd_pkg::sts_type      sts,
   output hcrd_pkg::rsp_type      rsp_data
);
   import hcrd_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = $clog2(MAX_DIGITS);
   localparam int SEQ_W = $clog2(MAX_DIGITS + 4);

   mode_type           mode_ff, mode_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [7:0]         val_ff, val_in;
   logic               over_ff, over_in;
   logic [7:0]         held_ff [MAX_DIGITS];
   logic               store;

   logic [SEQ_W-1:0]   seq_idx_ff, seq_last_ff;
   logic               tail_v_ff;
   logic [7:0]         tail_b_ff;
   logic               end_ff;
   rsp_type            rsp_ff, rsp_in;

   logic               flush_old, flush_new, do_flush, tail_v;
   logic [7:0]         tail_b;
   mode_type           src_mode;
   logic [CNT_W-1:0]   src_cnt;
   logic [SEQ_W-1:0]   flush_len;
   logic               len_one;
   logic [4:0]         hd;
   logic [SEQ_W-1:0]   seq_off;
   logic [7:0]         seq_byte;
   logic               seq_last;
   logic               load_out;

   // Next match state for the transaction on the input.
   always_comb begin
      mode_in   = mode_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      over_in   = over_ff;
      store     = 1'b0;
      flush_old = 1'b0;
      tail_v    = 1'b0;
      tail_b    = req_data.in_byte;
      hd        = hex_digit(req_data.in_byte);
      unique case (mode_ff)
         MODE_PLAIN: begin
            if (req_data.in_byte == CHAR_AMP) begin
               mode_in = MODE_AMP;
            end else begin
               tail_v = 1'b1;
            end
         end
         MODE_AMP: begin
            if (req_data.in_byte == CHAR_HASH) begin
               mode_in = MODE_HASH;
            end else begin
               flush_old = 1'b1;
               tail_v    = 1'b1;
            end
         end
         MODE_HASH: begin
            if (req_data.in_byte == CHAR_X) begin
               mode_in = MODE_HEX;
               cnt_in  = '0;
               val_in  = '0;
               over_in = 1'b0;
            end else begin
               flush_old = 1'b1;
               tail_v    = 1'b1;
            end
         end
         MODE_HEX: begin
            if (req_data.in_byte == CHAR_SEMI) begin
               tail_v  = 1'b1;
               tail_b  = val_ff;
               mode_in = MODE_PLAIN;
               cnt_in  = '0;
               val_in  = '0;
               over_in = 1'b0;
            end else if (cnt_ff >= CNT_W'(MAX_DIGITS)) begin
               flush_old = 1'b1;
               tail_v    = 1'b1;
            end else begin
               store  = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               if (!hd[4]) begin
                  over_in = 1'b1;
               end else if (!over_ff) begin
                  val_in = {val_ff[3:0], hd[3:0]};
               end
            end
         end
         default: begin
            mode_in = MODE_PLAIN;
         end
      endcase

      if (flush_old) begin
         mode_in = MODE_PLAIN;
         cnt_in  = '0;
         val_in  = '0;
         over_in = 1'b0;
      end

      // At end of stream whatever is still held goes out, including this byte.
      flush_new = req_data.in_end && (mode_in != MODE_PLAIN);
      src_mode  = flush_old ? mode_ff : mode_in;
      src_cnt   = flush_old ? cnt_ff : cnt_in;
      if (flush_new) begin
         mode_in = MODE_PLAIN;
         cnt_in  = '0;
         val_in  = '0;
         over_in = 1'b0;
      end
      do_flush  = flush_old || flush_new;
      flush_len = SEQ_W'(src_mode)
                + ((src_mode == MODE_HEX) ? SEQ_W'(src_cnt) : SEQ_W'(0));
      len_one   = (flush_len == SEQ_W'(1));
   end

   // Byte at the current position of a release: prefix, then held characters.
   always_comb begin
      seq_off = seq_idx_ff - SEQ_W'(3);
      if (seq_idx_ff == SEQ_W'(0)) begin
         seq_byte = CHAR_AMP;
      end else if (seq_idx_ff == SEQ_W'(1)) begin
         seq_byte = CHAR_HASH;
      end else if (seq_idx_ff == SEQ_W'(2)) begin
         seq_byte = CHAR_X;
      end else begin
         seq_byte = held_ff[seq_off[IDX_W-1:0]];
      end
      seq_last = (seq_idx_ff == seq_last_ff);
   end

   always_comb begin
      sts.first_emit    = do_flush || tail_v;
      sts.go_flush      = do_flush && !len_one;
      sts.go_tail       = do_flush && len_one && tail_v;
      sts.flush_at_last = seq_last;
      sts.tail_pend     = tail_v_ff;

      load_out = 1'b1;
      rsp_in   = rsp_ff;
      priority if (cmd.accept) begin
         load_out                = do_flush || tail_v;
         rsp_in.out_byte         = do_flush ? CHAR_AMP : tail_b;
         rsp_in.out_run_last     = do_flush ? (len_one && !tail_v) : 1'b1;
         rsp_in.out_stream_end   = rsp_in.out_run_last && req_data.in_end;
      end else if (cmd.emit_flush) begin
         rsp_in.out_byte         = seq_byte;
         rsp_in.out_run_last     = seq_last && !tail_v_ff;
         rsp_in.out_stream_end   = rsp_in.out_run_last && end_ff;
      end else if (cmd.emit_tail) begin
         rsp_in.out_byte         = tail_b_ff;
         rsp_in.out_run_last     = 1'b1;
         rsp_in.out_stream_end   = end_ff;
      end else begin
         load_out = 1'b0;
      end
   end

   assign rsp_data = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cnt_ff  <= '0;
         val_ff  <= '0;
         over_ff <= 1'b0;
      end else if (cmd.accept) begin
         mode_ff <= mode_in;
         cnt_ff  <= cnt_in;
         val_ff  <= val_in;
         over_ff <= over_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && store) begin
         held_ff[cnt_ff[IDX_W-1:0]] <= req_data.in_byte;
      end
      if (cmd.accept) begin
         seq_idx_ff  <= SEQ_W'(1);
         seq_last_ff <= flush_len - SEQ_W'(1);
         tail_v_ff   <= tail_v;
         tail_b_ff   <= tail_b;
         end_ff      <= req_data.in_end;
      end else if (cmd.emit_flush) begin
         seq_idx_ff  <= seq_idx_ff + SEQ_W'(1);
      end
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/hex_char_reference_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_char_reference_decoder_unit: hex numeric character reference decoder
// Replaces each "&#x...;" in a byte stream with the byte its hex digits name.
// ----------------------------------------------------------------------------
// A byte that produces at most one result is taken once the result register
// is free, so plain text flows at one transaction per cycle whenever the
// result side keeps up. A byte that releases held characters (a broken
// "&", "&#" or "&#x" sequence, a reference that runs past MAX_DIGITS
// characters, or the end of the stream inside a reference) produces
// between 1 and MAX_DIGITS + 4 results; the single result register is
// drained one released byte at a time, and the input is stalled until the
// last of them has been loaded. Bytes that only extend a pending reference
// produce no result and are taken once the result register is free. There
// is no clearing pass after reset: the held characters are read only below
// the running count. out_run_last marks the final result caused by one
// input transaction and out_stream_end marks the final result of the stream.
module hex_char_reference_decoder_unit #(
   parameter int MAX_DIGITS = hcrd_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hcrd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hcrd_pkg::rsp_type      rsp_data
);
   import hcrd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller owns the handshake and the result valid flag.
   hcrd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the match state, the held characters and the result.
   hcrd_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== rtl/hcrd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hcrd_checker: port-level assertions for the decoder
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
module hcrd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire hcrd_pkg::rsp_type rsp_data
);

   // A stalled result stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // While a run of results is incomplete no new input transaction is taken.
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_run_last |-> req_stall)
      else $error("input taken in the middle of a result run");

   // A blocked result register blocks the input.
   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while the result register is blocked");

   // The stream end flag only closes a run.
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_stream_end |-> rsp_data.out_run_last)
      else $error("stream end without run end");

   // Reset leaves no result pending.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind hex_char_reference_decoder_unit hcrd_checker u_checker (.*);
`default_nettype wire
